// ===== design/mioc_pkg.sv =====
package mioc_pkg;

  // Default number of stored settings registers.
  localparam int REG_COUNT_DEFAULT = 15;

  // Ports watched for the unlock sequence.
  localparam logic [15:0] SEQ_PORT_LO = 16'h02FA;
  localparam logic [15:0] SEQ_PORT_HI = 16'h03FA;

  // Fixed key byte of the third unlock write.
  localparam logic [7:0] UNLOCK_KEY = 8'h36;

  // Byte values that are not accepted as the first unlock write.
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  // Index that selects the window base and leaves configuration mode.
  localparam logic [3:0] INDEX_EXIT = 4'd15;

  // Settings register roles.
  localparam int SET_ENABLES = 0;
  localparam int SET_RTC     = 3;
  localparam int SET_UART1   = 4;
  localparam int SET_UART2   = 5;
  localparam int SET_LPT     = 6;
  localparam int SET_GAME    = 7;
  localparam int SET_IRQ     = 8;

  // Interrupt-select field codes.
  localparam logic [1:0] ROUTE_NONE  = 2'b00;
  localparam logic [1:0] ROUTE_RTC   = 2'b01;
  localparam logic [1:0] ROUTE_FIRST = 2'b10;
  localparam logic [1:0] ROUTE_OTHER = 2'b11;

  // Interrupt line numbers.
  localparam logic [3:0] IRQ_NONE = 4'd0;
  localparam logic [3:0] IRQ_3    = 4'd3;
  localparam logic [3:0] IRQ_4    = 4'd4;
  localparam logic [3:0] IRQ_5    = 4'd5;
  localparam logic [3:0] IRQ_7    = 4'd7;

  // Progress through the five-write unlock sequence.
  typedef enum logic [2:0] {
    STEP_IDLE       = 3'd0,
    STEP_HAVE_VALUE = 3'd1,
    STEP_HAVE_CMPL  = 3'd2,
    STEP_HAVE_KEY   = 3'd3,
    STEP_HAVE_BASE  = 3'd4
  } unlock_step_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] port;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [4:0] device_enables;
    logic [9:0] uart1_base;
    logic [9:0] uart2_base;
    logic [9:0] lpt_base;
    logic [9:0] game_base;
    logic [9:0] rtc_base;
    logic [3:0] uart1_irq;
    logic [3:0] uart2_irq;
    logic [3:0] lpt_irq;
    logic [3:0] rtc_irq;
  } rsp_t;

  // Power-on contents of the settings store.
  function automatic logic [7:0] store_reset_value(input logic [3:0] idx);
    logic [7:0] v;
    v = 8'h00;
    unique case (idx)
      4'd3:    v = 8'hB0;
      4'd4:    v = 8'hFE;
      4'd5:    v = 8'hBE;
      4'd6:    v = 8'h9E;
      4'd7:    v = 8'h80;
      4'd8:    v = 8'hEC;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== design/mioc_chan_if.sv =====
interface mioc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== design/multifunction_io_config_unlock.sv =====
// Configuration unlock and resource map of a multifunction I/O controller. Each bus
// access request (read or write, 16-bit port, data byte) yields one response with the
// read byte and the live resource map: device enables, port bases and interrupt routing.
// A five-write sequence on 0x2FA/0x3FA (V, ~V, 0x36, W, ~W) enters configuration mode,
// opens an index/data window at W*4 and W*4+1 and disables every device; writing the
// data port with index 15 leaves configuration mode and makes the map live again.
// Each request is decoded and applied to the state registers in the cycle it is
// accepted, and its response is held in the output register the next cycle.
// A new request is taken every cycle, also while a response waits, as long as the
// output register is empty or being drained; the only loop is the registered update
// of the unlock and settings registers.
module multifunction_io_config_unlock #(
  parameter int REG_COUNT = mioc_pkg::REG_COUNT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  mioc_chan_if.sink   req,
  mioc_chan_if.source rsp
);

  localparam int IDX_W = $clog2(REG_COUNT);

  // State registers.
  mioc_pkg::unlock_step_t unlock_step, unlock_step_next;
  logic [7:0] held_value, held_value_next;
  logic       config_active, config_active_next;
  logic       window_open, window_open_next;
  logic [7:0] window_base_quarter, window_base_quarter_next;
  logic [3:0] selected_index, selected_index_next;
  logic       map_live, map_live_next;
  logic [7:0] store      [REG_COUNT];
  logic [7:0] store_next [REG_COUNT];

  mioc_pkg::req_t r;
  mioc_pkg::rsp_t rsp_next;

  logic accept;
  logic is_write;
  logic hit_idx, hit_dat, in_window, window_live;
  logic seq_lo, seq_hi, seq_port, advance;
  logic sel_in_store;
  logic [7:0] store_rd;

  // Map decode inputs.
  logic [3:0] en;
  logic [7:0] s8;
  logic [3:0] u1, u2, lp, rt;

  assign r         = req.payload;
  // Take a request whenever the output register is empty or drains this cycle.
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_write  = r.operation;

  // Window ports: index at base*4, data right after it.
  assign hit_idx   = (r.port == {6'b0, window_base_quarter, 2'b00});
  assign hit_dat   = (r.port == {6'b0, window_base_quarter, 2'b01});
  assign in_window = window_open && (hit_idx || hit_dat);
  assign window_live = in_window && config_active;

  assign seq_lo   = (r.port == mioc_pkg::SEQ_PORT_LO);
  assign seq_hi   = (r.port == mioc_pkg::SEQ_PORT_HI);
  assign seq_port = seq_lo || seq_hi;

  assign sel_in_store = (selected_index < 4'(REG_COUNT));
  assign store_rd     = sel_in_store ? store[selected_index[IDX_W-1:0]] : 8'h00;

  // Next state of the unlock sequencer and the settings store.
  always_comb begin
    unlock_step_next         = unlock_step;
    held_value_next          = held_value;
    config_active_next       = config_active;
    window_open_next         = window_open;
    window_base_quarter_next = window_base_quarter;
    selected_index_next      = selected_index;
    map_live_next            = map_live;
    store_next               = store;
    advance                  = 1'b0;

    if (accept && is_write) begin
      if (seq_lo) begin
        if (unlock_step == mioc_pkg::STEP_IDLE && r.write_data != mioc_pkg::BYTE_ZERO &&
            r.write_data != mioc_pkg::BYTE_ONES) begin
          advance         = 1'b1;
          held_value_next = r.write_data;
        end else if (unlock_step == mioc_pkg::STEP_HAVE_BASE) begin
          if ((r.write_data | held_value) == mioc_pkg::BYTE_ONES) begin
            // Enter configuration mode: move the window, drop every device.
            window_base_quarter_next = held_value;
            window_open_next         = 1'b1;
            config_active_next       = 1'b1;
            map_live_next            = 1'b0;
          end else begin
            // Failed final write: leave config mode, keep devices as they are.
            config_active_next = 1'b0;
          end
        end
      end else if (seq_hi) begin
        priority if (unlock_step == mioc_pkg::STEP_HAVE_VALUE &&
                     (r.write_data | held_value) == mioc_pkg::BYTE_ONES) begin
          advance = 1'b1;
        end else if (unlock_step == mioc_pkg::STEP_HAVE_CMPL &&
                     r.write_data == mioc_pkg::UNLOCK_KEY) begin
          advance = 1'b1;
        end else if (unlock_step == mioc_pkg::STEP_HAVE_KEY) begin
          held_value_next = r.write_data;
          advance         = 1'b1;
        end else begin
          advance = 1'b0;
        end
      end else if (window_live) begin
        if (hit_idx) begin
          selected_index_next = r.write_data[3:0];
        end else if (selected_index == mioc_pkg::INDEX_EXIT) begin
          // Exit configuration mode and apply the map.
          config_active_next = 1'b0;
          window_open_next   = 1'b0;
          map_live_next      = 1'b1;
        end else if (sel_in_store) begin
          store_next[selected_index[IDX_W-1:0]] = r.write_data;
        end
      end

      // Any decoded write that does not advance restarts the sequence.
      if (seq_port && advance) begin
        unlock_step_next = mioc_pkg::unlock_step_t'(unlock_step + 3'd1);
      end else if (seq_port || in_window) begin
        unlock_step_next = mioc_pkg::STEP_IDLE;
      end
    end
  end

  // Response: read byte plus the map as it stands after this request.
  always_comb begin
    en = store_next[mioc_pkg::SET_ENABLES][3:0];
    s8 = store_next[mioc_pkg::SET_IRQ];
    u1 = mioc_pkg::IRQ_NONE;
    u2 = mioc_pkg::IRQ_NONE;
    lp = mioc_pkg::IRQ_NONE;
    rt = mioc_pkg::IRQ_NONE;

    // Interrupt-select fields, later ones override earlier ones.
    unique case (s8[7:6])
      mioc_pkg::ROUTE_RTC:   rt = mioc_pkg::IRQ_3;
      mioc_pkg::ROUTE_FIRST: u1 = mioc_pkg::IRQ_3;
      mioc_pkg::ROUTE_OTHER: u2 = mioc_pkg::IRQ_3;
      default: ;
    endcase
    unique case (s8[5:4])
      mioc_pkg::ROUTE_RTC:   rt = mioc_pkg::IRQ_4;
      mioc_pkg::ROUTE_FIRST: u1 = mioc_pkg::IRQ_4;
      mioc_pkg::ROUTE_OTHER: u2 = mioc_pkg::IRQ_4;
      default: ;
    endcase
    unique case (s8[3:2])
      mioc_pkg::ROUTE_RTC:   rt = mioc_pkg::IRQ_5;
      mioc_pkg::ROUTE_FIRST: u1 = mioc_pkg::IRQ_5;
      mioc_pkg::ROUTE_OTHER: lp = mioc_pkg::IRQ_5;
      default: ;
    endcase
    unique case (s8[1:0])
      mioc_pkg::ROUTE_RTC:   rt = mioc_pkg::IRQ_7;
      mioc_pkg::ROUTE_FIRST: u2 = mioc_pkg::IRQ_7;
      mioc_pkg::ROUTE_OTHER: lp = mioc_pkg::IRQ_7;
      default: ;
    endcase

    rsp_next = '0;

    // Reads see the window only while config mode is on; writes return zero.
    if (!is_write) begin
      rsp_next.read_data = mioc_pkg::BYTE_ONES;
      if (window_live) begin
        if (hit_idx) begin
          rsp_next.read_data = {4'b0, selected_index};
        end else if (selected_index == mioc_pkg::INDEX_EXIT) begin
          rsp_next.read_data = window_base_quarter;
        end else if (sel_in_store) begin
          rsp_next.read_data = store_rd;
        end
      end
    end

    if (map_live_next) begin
      rsp_next.device_enables = {1'b1, en};
      rsp_next.uart1_base = en[1] ? {store_next[mioc_pkg::SET_UART1], 2'b00} : 10'd0;
      rsp_next.uart2_base = en[2] ? {store_next[mioc_pkg::SET_UART2], 2'b00} : 10'd0;
      rsp_next.lpt_base   = en[3] ? {store_next[mioc_pkg::SET_LPT], 2'b00} : 10'd0;
      rsp_next.game_base  = en[0] ? {store_next[mioc_pkg::SET_GAME], 2'b00} : 10'd0;
      rsp_next.rtc_base   = {store_next[mioc_pkg::SET_RTC], 2'b00};
      rsp_next.uart1_irq  = en[1] ? u1 : mioc_pkg::IRQ_NONE;
      rsp_next.uart2_irq  = en[2] ? u2 : mioc_pkg::IRQ_NONE;
      rsp_next.lpt_irq    = en[3] ? lp : mioc_pkg::IRQ_NONE;
      rsp_next.rtc_irq    = rt;
    end
  end

  // State and settings registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_step         <= mioc_pkg::STEP_IDLE;
      held_value          <= 8'h00;
      config_active       <= 1'b0;
      window_open         <= 1'b0;
      window_base_quarter <= 8'h00;
      selected_index      <= 4'd0;
      map_live            <= 1'b1;
      for (int i = 0; i < REG_COUNT; i++) begin
        store[i] <= mioc_pkg::store_reset_value(4'(i));
      end
    end else begin
      unlock_step         <= unlock_step_next;
      held_value          <= held_value_next;
      config_active       <= config_active_next;
      window_open         <= window_open_next;
      window_base_quarter <= window_base_quarter_next;
      selected_index      <= selected_index_next;
      map_live            <= map_live_next;
      store               <= store_next;
    end
  end

  // Output register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.payload <= rsp_next;
    end
  end

  // The window is open exactly while the map is held off.
  a_window_vs_map: assert property (@(posedge clk) disable iff (rst)
    window_open != map_live)
    else $error("window state and map state disagree");

  // Config mode only exists with an open window.
  a_config_needs_window: assert property (@(posedge clk) disable iff (rst)
    config_active |-> window_open)
    else $error("config mode active without window");

  // Every accepted request leaves a response in the output register.
  a_accept_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted request produced no response");

  // Reads never change the sequencer or window.
  a_read_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_write) |=> ($stable(unlock_step) && $stable(window_open) &&
                               $stable(config_active) && $stable(selected_index)))
    else $error("read access changed state");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int REG_COUNT = mioc_pkg::REG_COUNT_DEFAULT;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Run shape: total requests, quiet tail with no idling, receiver hold-off length.
  localparam int REQUEST_TARGET = 1350;
  localparam int QUIET_TAIL     = 150;
  localparam int HOLD_AT        = 500;
  localparam int PAUSE_AT       = 900;
  localparam int HOLD_CYCLES    = 60;
  localparam int SHUFFLE_EVERY  = 64;

  // Directed unlock values: first session opens the window at 0x2F8/0x2F9.
  localparam logic [7:0]  FIRST_KEY  = 8'h5A;
  localparam logic [7:0]  SECOND_KEY = 8'hFE;
  localparam logic [7:0]  BAD_BASE   = 8'h80;
  localparam logic [7:0]  DIR_BASE   = 8'hBE;
  localparam logic [15:0] DIR_IDX    = {6'd0, DIR_BASE, 2'b00};
  localparam logic [15:0] DIR_DAT    = DIR_IDX + 16'd1;

  // Power-on map: only the rtc is live, at 0xB0 * 4, with no interrupt routed to it.
  localparam mioc_pkg::rsp_t POWER_ON_MISS = '{read_data: mioc_pkg::BYTE_ONES,
                                               device_enables: 5'h10,
                                               rtc_base: 10'h2C0, default: '0};
  localparam mioc_pkg::rsp_t POWER_ON_WRITE = '{read_data: mioc_pkg::BYTE_ZERO,
                                                device_enables: 5'h10,
                                                rtc_base: 10'h2C0, default: '0};

  typedef struct {
    logic           write;
    logic [15:0]    port;
    logic [7:0]     data;
    bit             typed;
    mioc_pkg::rsp_t want;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mioc_chan_if #(.payload_t(mioc_pkg::req_t)) req_ch ();
  mioc_chan_if #(.payload_t(mioc_pkg::rsp_t)) rsp_ch ();

  multifunction_io_config_unlock DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #500000;
    $display("FAIL multifunction_io_config_unlock");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predicted device state, kept in step with every accepted request.
  // ---------------------------------------------------------------------------
  mioc_pkg::unlock_step_t unlock_at = mioc_pkg::STEP_IDLE;
  logic [7:0]   latched_byte   = 8'h00;
  bit           config_on      = 1'b0;
  bit           window_on      = 1'b0;
  logic [7:0]   window_quarter = 8'h00;
  logic [3:0]   chosen_index   = 4'd0;
  bit           map_on         = 1'b1;
  logic [7:0]   settings [15]  = '{8'h00, 8'h00, 8'h00, 8'hB0, 8'hFE, 8'hBE, 8'h9E, 8'h80,
                                   8'hEC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

  mioc_pkg::rsp_t expected_maps [$];
  int   mismatches    = 0;
  int   responses_seen = 0;
  int   requests_sent  = 0;

  // Side channel for directed rows whose response is typed into the script.
  bit             typed_on  = 1'b0;
  mioc_pkg::rsp_t typed_rsp = '0;

  // Idling controls shared by the sender and receiver processes.
  bit sender_gaps     = 1'b1;
  bit receiver_stalls = 1'b1;
  bit hold_off        = 1'b0;

  function automatic logic [7:0] setting_at(input int i);
    return (i < REG_COUNT) ? settings[i] : 8'h00;
  endfunction

  // Build the live resource map from the enable and interrupt-select settings.
  function automatic mioc_pkg::rsp_t resource_map();
    logic [7:0] en_byte;
    logic [3:0] en;
    logic [7:0] route;
    logic [3:0] u1, u2, lp, rt;
    mioc_pkg::rsp_t m;
    en_byte = setting_at(mioc_pkg::SET_ENABLES);
    en = en_byte[3:0];
    route = setting_at(mioc_pkg::SET_IRQ);
    u1 = mioc_pkg::IRQ_NONE;
    u2 = mioc_pkg::IRQ_NONE;
    lp = mioc_pkg::IRQ_NONE;
    rt = mioc_pkg::IRQ_NONE;
    // Walk the four fields high to low so a later field overrides an earlier one.
    case (route[7:6])
      mioc_pkg::ROUTE_RTC:   rt = mioc_pkg::IRQ_3;
      mioc_pkg::ROUTE_FIRST: u1 = mioc_pkg::IRQ_3;
      mioc_pkg::ROUTE_OTHER: u2 = mioc_pkg::IRQ_3;
      default: ;
    endcase
    case (route[5:4])
      mioc_pkg::ROUTE_RTC:   rt = mioc_pkg::IRQ_4;
      mioc_pkg::ROUTE_FIRST: u1 = mioc_pkg::IRQ_4;
      mioc_pkg::ROUTE_OTHER: u2 = mioc_pkg::IRQ_4;
      default: ;
    endcase
    case (route[3:2])
      mioc_pkg::ROUTE_RTC:   rt = mioc_pkg::IRQ_5;
      mioc_pkg::ROUTE_FIRST: u1 = mioc_pkg::IRQ_5;
      mioc_pkg::ROUTE_OTHER: lp = mioc_pkg::IRQ_5;
      default: ;
    endcase
    case (route[1:0])
      mioc_pkg::ROUTE_RTC:   rt = mioc_pkg::IRQ_7;
      mioc_pkg::ROUTE_FIRST: u2 = mioc_pkg::IRQ_7;
      mioc_pkg::ROUTE_OTHER: lp = mioc_pkg::IRQ_7;
      default: ;
    endcase
    m = '0;
    if (map_on) begin
      m.device_enables = {1'b1, en};
      m.uart1_base = en[1] ? {setting_at(mioc_pkg::SET_UART1), 2'b00} : 10'd0;
      m.uart2_base = en[2] ? {setting_at(mioc_pkg::SET_UART2), 2'b00} : 10'd0;
      m.lpt_base   = en[3] ? {setting_at(mioc_pkg::SET_LPT), 2'b00} : 10'd0;
      m.game_base  = en[0] ? {setting_at(mioc_pkg::SET_GAME), 2'b00} : 10'd0;
      m.rtc_base   = {setting_at(mioc_pkg::SET_RTC), 2'b00};
      m.uart1_irq  = en[1] ? u1 : mioc_pkg::IRQ_NONE;
      m.uart2_irq  = en[2] ? u2 : mioc_pkg::IRQ_NONE;
      m.lpt_irq    = en[3] ? lp : mioc_pkg::IRQ_NONE;
      m.rtc_irq    = rt;
    end
    return m;
  endfunction

  // Apply one bus access to the predicted state and return its response.
  function automatic mioc_pkg::rsp_t apply_bus_access(input mioc_pkg::req_t a);
    logic [15:0] idx_port, dat_port;
    bit in_win, on_seq, advance;
    logic [7:0] rd;
    mioc_pkg::rsp_t r;
    idx_port = {6'd0, window_quarter, 2'b00};
    dat_port = idx_port + 16'd1;
    in_win = window_on && (a.port == idx_port || a.port == dat_port);
    rd = mioc_pkg::BYTE_ONES;
    if (a.operation == OP_READ) begin
      // Reads decode only inside an open window in configuration mode.
      if (in_win && config_on) begin
        if (a.port == idx_port) begin
          rd = {4'h0, chosen_index};
        end else if (chosen_index == mioc_pkg::INDEX_EXIT) begin
          rd = window_quarter;
        end else if (chosen_index < REG_COUNT) begin
          rd = settings[chosen_index];
        end
      end
    end else begin
      on_seq = (a.port == mioc_pkg::SEQ_PORT_LO || a.port == mioc_pkg::SEQ_PORT_HI);
      advance = 1'b0;
      if (a.port == mioc_pkg::SEQ_PORT_LO) begin
        if (unlock_at == mioc_pkg::STEP_IDLE && a.write_data != mioc_pkg::BYTE_ZERO
            && a.write_data != mioc_pkg::BYTE_ONES) begin
          advance = 1'b1;
          latched_byte = a.write_data;
        end else if (unlock_at == mioc_pkg::STEP_HAVE_BASE) begin
          if ((a.write_data | latched_byte) == mioc_pkg::BYTE_ONES) begin
            window_quarter = latched_byte;
            window_on = 1'b1;
            config_on = 1'b1;
            map_on = 1'b0;
          end else begin
            // Failed final write: drop config mode, keep the window and the map as they are.
            config_on = 1'b0;
          end
        end
      end else if (a.port == mioc_pkg::SEQ_PORT_HI) begin
        if (unlock_at == mioc_pkg::STEP_HAVE_VALUE &&
            (a.write_data | latched_byte) == mioc_pkg::BYTE_ONES) begin
          advance = 1'b1;
        end else if (unlock_at == mioc_pkg::STEP_HAVE_CMPL &&
                     a.write_data == mioc_pkg::UNLOCK_KEY) begin
          advance = 1'b1;
        end else if (unlock_at == mioc_pkg::STEP_HAVE_KEY) begin
          latched_byte = a.write_data;
          advance = 1'b1;
        end
      end else if (in_win && config_on) begin
        if (a.port == idx_port) begin
          chosen_index = a.write_data[3:0];
        end else if (chosen_index == mioc_pkg::INDEX_EXIT) begin
          config_on = 1'b0;
          window_on = 1'b0;
          map_on = 1'b1;
        end else if (chosen_index < REG_COUNT) begin
          settings[chosen_index] = a.write_data;
        end
      end
      // Any decoded write that does not advance restarts the sequence.
      if (on_seq && advance) begin
        unlock_at = mioc_pkg::unlock_step_t'(unlock_at + 3'd1);
      end else if (on_seq || in_win) begin
        unlock_at = mioc_pkg::STEP_IDLE;
      end
      rd = mioc_pkg::BYTE_ZERO;
    end
    r = resource_map();
    r.read_data = rd;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got, inout bit bad);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("mismatch on %s in response %0d: expected %0h, got %0h",
                 name, responses_seen, want, got);
      end
      bad = 1'b1;
    end
  endtask

  task automatic check_response(input mioc_pkg::rsp_t got);
    mioc_pkg::rsp_t want;
    bit bad;
    bad = 1'b0;
    if (expected_maps.size() == 0) begin
      if (mismatches < 10) begin
        $display("response %0d arrived with no request outstanding", responses_seen);
      end
      mismatches++;
    end else begin
      want = expected_maps.pop_front();
      compare_field("read_data", 16'(want.read_data), 16'(got.read_data), bad);
      compare_field("device_enables", 16'(want.device_enables),
                    16'(got.device_enables), bad);
      compare_field("uart1_base", 16'(want.uart1_base), 16'(got.uart1_base), bad);
      compare_field("uart2_base", 16'(want.uart2_base), 16'(got.uart2_base), bad);
      compare_field("lpt_base", 16'(want.lpt_base), 16'(got.lpt_base), bad);
      compare_field("game_base", 16'(want.game_base), 16'(got.game_base), bad);
      compare_field("rtc_base", 16'(want.rtc_base), 16'(got.rtc_base), bad);
      compare_field("uart1_irq", 16'(want.uart1_irq), 16'(got.uart1_irq), bad);
      compare_field("uart2_irq", 16'(want.uart2_irq), 16'(got.uart2_irq), bad);
      compare_field("lpt_irq", 16'(want.lpt_irq), 16'(got.lpt_irq), bad);
      compare_field("rtc_irq", 16'(want.rtc_irq), 16'(got.rtc_irq), bad);
      if (bad) begin
        mismatches++;
      end
    end
    responses_seen++;
  endtask

  // Sample both channels at the rising edge. Check the response before queueing
  // the new request: a response never belongs to a request taken on the same edge.
  always @(posedge clk) begin : monitor
    mioc_pkg::rsp_t predicted;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_response(rsp_ch.payload);
      end
      if (req_ch.valid && req_ch.ready) begin
        predicted = apply_bus_access(req_ch.payload);
        expected_maps.push_back(typed_on ? typed_rsp : predicted);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, none in the tail.
  // ---------------------------------------------------------------------------
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        // Hold off long enough for the output register to fill and stall requests.
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
        rsp_ch.ready = 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one request at the falling edge, optionally after an idle burst,
  // and hold it until the rising edge that accepts it.
  task automatic issue(input logic op, input logic [15:0] addr, input logic [7:0] wdata,
                       input bit typed = 1'b0, input mioc_pkg::rsp_t want = '0);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.payload = '{operation: op, port: addr, write_data: wdata};
    typed_on = typed;
    typed_rsp = want;
    do @(posedge clk); while (!req_ch.ready);
    requests_sent++;
  endtask

  // Drop valid and wait for every outstanding response to come back.
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Directed opening: extremes, a full unlock with register access, then a failed
  // final unlock write inside configuration mode and the dead window it leaves.
  script_row_t script [SCRIPT_LEN] = '{
    '{OP_READ,  16'h0000,             mioc_pkg::BYTE_ZERO, 1'b1, POWER_ON_MISS},
    '{OP_WRITE, 16'hFFFF,             mioc_pkg::BYTE_ONES, 1'b1, POWER_ON_WRITE},
    '{OP_READ,  mioc_pkg::SEQ_PORT_LO, mioc_pkg::BYTE_ZERO, 1'b1, POWER_ON_MISS},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_LO, mioc_pkg::BYTE_ZERO, 1'b1, POWER_ON_WRITE},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_LO, FIRST_KEY,   1'b0, '0},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_HI, ~FIRST_KEY,  1'b0, '0},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_HI, mioc_pkg::UNLOCK_KEY, 1'b0, '0},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_HI, DIR_BASE,    1'b0, '0},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_LO, ~DIR_BASE,   1'b0, '0},
    '{OP_READ,  DIR_IDX,     mioc_pkg::BYTE_ZERO,   1'b0, '0},
    '{OP_WRITE, DIR_IDX,     8'(mioc_pkg::SET_IRQ), 1'b0, '0},
    '{OP_READ,  DIR_DAT,     mioc_pkg::BYTE_ZERO,   1'b0, '0},
    '{OP_WRITE, DIR_DAT,     mioc_pkg::BYTE_ONES,   1'b0, '0},
    '{OP_WRITE, DIR_IDX,     8'(mioc_pkg::SET_ENABLES), 1'b0, '0},
    '{OP_WRITE, DIR_DAT,     8'h0F,       1'b0, '0},
    '{OP_WRITE, DIR_IDX,     {4'hF, mioc_pkg::INDEX_EXIT}, 1'b0, '0},
    '{OP_READ,  DIR_DAT,     mioc_pkg::BYTE_ZERO,   1'b0, '0},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_LO, SECOND_KEY,  1'b0, '0},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_HI, ~SECOND_KEY, 1'b0, '0},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_HI, mioc_pkg::UNLOCK_KEY, 1'b0, '0},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_HI, BAD_BASE,    1'b0, '0},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_LO, mioc_pkg::BYTE_ZERO, 1'b0, '0},
    '{OP_READ,  DIR_DAT,     mioc_pkg::BYTE_ZERO,   1'b0, '0},
    '{OP_WRITE, DIR_IDX,     8'h0F,       1'b0, '0},
    '{OP_WRITE, mioc_pkg::SEQ_PORT_LO, mioc_pkg::BYTE_ONES, 1'b0, '0}
  };

  initial begin
    logic [7:0] v, w, d;
    logic [15:0] p, ip;
    int bad_step, n, pick, next_shuffle;
    bit hold_started;
    bit pause_done;
    hold_started = 1'b0;
    pause_done = 1'b0;
    next_shuffle = SHUFFLE_EVERY;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;

    // Hold reset, then release it at a falling edge.
    repeat (9) @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      issue(script[i].write, script[i].port, script[i].data, script[i].typed,
            script[i].want);
    end
    drain();

    while (requests_sent < REQUEST_TARGET) begin
      // Reshuffle idling per chunk; shut it off for the tail of the run.
      if (requests_sent >= REQUEST_TARGET - QUIET_TAIL) begin
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
      end else if (requests_sent >= next_shuffle) begin
        sender_gaps = ($urandom_range(0, 2) != 0);
        receiver_stalls = ($urandom_range(0, 2) != 0);
        next_shuffle += SHUFFLE_EVERY;
      end
      if (!hold_started && requests_sent >= HOLD_AT) begin
        // Keep offering requests while the receiver holds off.
        hold_started = 1'b1;
        hold_off = 1'b1;
      end
      if (!pause_done && requests_sent >= PAUSE_AT) begin
        // Stop sending until every outstanding response is back.
        pause_done = 1'b1;
        drain();
      end

      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // Unlock attempt, mostly well formed, with one step broken now and then.
        v = 8'($urandom_range(1, 254));
        w = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3) * 85) : 8'($urandom);
        bad_step = $urandom_range(0, 19);
        for (int s = 0; s < 5; s++) begin
          case (s)
            0: begin p = mioc_pkg::SEQ_PORT_LO; d = v; end
            1: begin
              p = mioc_pkg::SEQ_PORT_HI;
              d = ~v | (($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
            end
            2: begin p = mioc_pkg::SEQ_PORT_HI; d = mioc_pkg::UNLOCK_KEY; end
            3: begin p = mioc_pkg::SEQ_PORT_HI; d = w; end
            default: begin
              p = mioc_pkg::SEQ_PORT_LO;
              d = ~w | (($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
            end
          endcase
          if (s == bad_step) begin
            if ($urandom_range(0, 1) == 0) begin
              d = 8'($urandom);
            end else begin
              p = (p == mioc_pkg::SEQ_PORT_LO) ? mioc_pkg::SEQ_PORT_HI
                                               : mioc_pkg::SEQ_PORT_LO;
            end
          end
          // Reads between steps must not disturb the sequence.
          if ($urandom_range(0, 7) == 0) begin
            issue(OP_READ, 16'($urandom), 8'($urandom));
          end
          issue(OP_WRITE, p, d);
        end

        // Work the window: select, store and read back registers.
        ip = {6'd0, w, 2'b00};
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
          case ($urandom_range(0, 5))
            0: begin
              d = 8'($urandom);
              if ($urandom_range(0, 2) != 0) begin
                d[3:0] = 4'($urandom_range(0, 8));
              end
              issue(OP_WRITE, ip, d);
            end
            1, 2: issue(OP_WRITE, ip + 16'd1, 8'($urandom));
            3: issue(OP_READ, ip + 16'd1, 8'($urandom));
            4: issue(OP_READ, ip, 8'($urandom));
            default: issue(OP_READ, 16'($urandom), 8'($urandom));
          endcase
        end

        // Usually leave configuration mode; otherwise let a later unlock re-enter.
        if ($urandom_range(0, 3) != 0) begin
          issue(OP_WRITE, ip, {4'($urandom), mioc_pkg::INDEX_EXIT});
          if ($urandom_range(0, 1) == 0) begin
            issue(OP_READ, ip + 16'd1, 8'($urandom));
          end
          issue(OP_WRITE, ip + 16'd1, 8'($urandom));
        end
      end else if (pick <= 7) begin
        // Noise on the sequence ports.
        issue(1'($urandom),
              ($urandom_range(0, 1) == 0) ? mioc_pkg::SEQ_PORT_LO : mioc_pkg::SEQ_PORT_HI,
              8'($urandom));
      end else begin
        // Noise anywhere in the port space.
        issue(1'($urandom), 16'($urandom), 8'($urandom));
      end
    end

    // Let the last responses arrive and catch any stray one before the verdict.
    drain();
    if (mismatches == 0) begin
      $display("PASS multifunction_io_config_unlock");
    end else begin
      $display("FAIL multifunction_io_config_unlock");
    end
    $finish;
  end

endmodule
